// ===== hw/rtl/cartridge_page_read_sequencer_top_macros.svh =====
// Assertion macros shared by the page read sequencer modules.
`ifndef CARTRIDGE_PAGE_READ_SEQUENCER_TOP_MACROS_SVH
`define CARTRIDGE_PAGE_READ_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CPRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cprs check failed");

// Next-cycle implication, held off during reset.
`define CPRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cprs check failed");

`endif

// ===== hw/rtl/cprs_pkg.sv =====
// Types, codes and constants shared by the page read sequencer.
`default_nettype none
package cprs_pkg;

    localparam int unsigned PAGE_BYTES_DEF = 512;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam logic [7:0] READ_PAGE_OPCODE = 8'hB7;

    // Input item kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_WORD  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Configuration register index
    localparam logic REG_PAGE_READ_CONTROL = 1'b0;

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_CMD  = 2'd1,
        TAIL_DONE = 2'd2
    } t_tail;

    typedef struct packed {
        logic        action;
        logic [23:0] count;
        logic [31:0] data;
    } t_req;

    // One queue entry holds every result of one input item
    typedef struct packed {
        logic        wr_en;
        logic [23:0] offset;
        logic [31:0] data;
        t_tail       tail;
        logic [31:0] page;
        logic [31:0] ctrl;
    } t_entry;

endpackage
`default_nettype wire

// ===== hw/rtl/cprs_split.sv =====
// Address splitter: page base and misalignment by reciprocal multiply, three stages.
`default_nettype none
module cprs_split #(
    parameter int unsigned PAGE_BYTES = cprs_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire cprs_pkg::t_req                i_req,
    input  wire logic [31:0]                   i_addr,
    output logic                               o_valid,
    output cprs_pkg::t_req                     o_req,
    output logic [$clog2(PAGE_BYTES)-1:0]      o_mis,
    output logic [31:0]                        o_base
);
    import cprs_pkg::*;

    localparam int unsigned LOG_D = $clog2(PAGE_BYTES);
    localparam int unsigned K     = 32 + LOG_D;
    localparam int unsigned Q_W   = 33 - LOG_D;
    localparam int unsigned D_W   = $clog2(PAGE_BYTES + 1);
    localparam logic [32:0] RECIP = 33'((65'(1) << K) / 65'(PAGE_BYTES));
    localparam logic [D_W-1:0] D_C  = D_W'(PAGE_BYTES);
    localparam logic [31:0]    D_32 = 32'(PAGE_BYTES);

    logic [64:0]        prod_c;
    logic [Q_W+D_W-1:0] qd_c;
    logic [31:0]        rem_c;
    logic               corr_c;
    logic [31:0]        mis_c;
    logic [31:0]        base_c;

    logic               r_v1, r_v2, r_v3;
    t_req               r_req1, r_req2, r_req3;
    logic [31:0]        r_addr1, r_addr2;
    logic [Q_W-1:0]     r_q1;
    logic [31:0]        r_qd2;
    logic [LOG_D-1:0]   r_mis3;
    logic [31:0]        r_base3;

    // Quotient estimate is exact or one short; the last stage corrects it
    assign prod_c = {33'b0, i_addr} * {32'b0, RECIP};
    assign qd_c   = r_q1 * D_C;
    assign rem_c  = r_addr2 - r_qd2;
    assign corr_c = rem_c >= D_32;
    assign mis_c  = corr_c ? rem_c - D_32 : rem_c;
    assign base_c = corr_c ? r_qd2 + D_32 : r_qd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_req1  <= i_req;
            r_addr1 <= i_addr;
            r_q1    <= prod_c[K +: Q_W];
            r_req2  <= r_req1;
            r_addr2 <= r_addr1;
            r_qd2   <= qd_c[31:0];
            r_req3  <= r_req2;
            r_mis3  <= mis_c[LOG_D-1:0];
            r_base3 <= base_c;
        end
    end

    assign o_valid = r_v3;
    assign o_req   = r_req3;
    assign o_mis   = r_mis3;
    assign o_base  = r_base3;

endmodule
`default_nettype wire

// ===== hw/rtl/cprs_front.sv =====
// Front end: accepts items, tracks the request and packs its results into one entry.
`default_nettype none
`include "cartridge_page_read_sequencer_top_macros.svh"
module cprs_front #(
    parameter int unsigned PAGE_BYTES = cprs_pkg::PAGE_BYTES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cprs_pkg::t_req  i_req,
    input  wire logic [31:0]     i_addr,
    input  wire logic [31:0]     i_ctrl,
    input  wire logic            i_full,
    output logic                 o_push,
    output cprs_pkg::t_entry     o_entry
);
    import cprs_pkg::*;

    localparam int unsigned PAGE_WORDS = PAGE_BYTES / 4;
    localparam int unsigned WL_W       = $clog2(PAGE_WORDS + 1);
    localparam int unsigned MIS_W      = $clog2(PAGE_BYTES);
    localparam logic [WL_W-1:0] WL_FULL = WL_W'(PAGE_WORDS);
    localparam logic [31:0]     PB_32   = 32'(PAGE_BYTES);

    logic              adv;
    logic              s_valid;
    t_req              s_req;
    logic [MIS_W-1:0]  s_mis;
    logic [31:0]       s_base;

    logic [31:0]        r_page;
    logic signed [25:0] r_off;
    logic [WL_W-1:0]    r_words_left;
    logic               r_busy;
    logic [23:0]        r_count;

    logic               is_start, is_word;
    logic               start_more, word_more, in_win, page_end;
    logic signed [25:0] cnt_s, n_off, neg_mis;
    logic [31:0]        n_page;
    t_entry             entry_c;

    // The whole front moves together whenever the queue has a free slot
    assign adv     = !i_full;
    assign o_ready = adv;

    cprs_split #(.PAGE_BYTES(PAGE_BYTES)) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_req   (i_req),
        .i_addr  (i_addr),
        .o_valid (s_valid),
        .o_req   (s_req),
        .o_mis   (s_mis),
        .o_base  (s_base)
    );

    assign is_start   = s_valid && (s_req.action == ACT_START) && !r_busy;
    assign is_word    = s_valid && (s_req.action == ACT_WORD) && r_busy;
    assign cnt_s      = $signed({2'b00, r_count});
    assign n_off      = r_off + 26'sd4;
    assign n_page     = r_page + PB_32;
    assign neg_mis    = $signed(26'd0 - 26'(s_mis));
    // Misaligned starts always read a page; aligned ones only with a non-zero count
    assign start_more = (s_mis != '0) || (s_req.count != '0);
    assign in_win     = !r_off[25] && (r_off < cnt_s);
    assign page_end   = r_words_left == WL_W'(1);
    assign word_more  = n_off < cnt_s;

    always_comb begin
        entry_c        = '0;
        entry_c.ctrl   = i_ctrl;
        entry_c.data   = s_req.data;
        entry_c.offset = r_off[23:0];
        if (is_start) begin
            entry_c.wr_en = 1'b0;
            entry_c.page  = s_base;
            entry_c.tail  = start_more ? TAIL_CMD : TAIL_DONE;
        end else begin
            entry_c.wr_en = in_win;
            entry_c.page  = n_page;
            if (page_end) begin
                entry_c.tail = word_more ? TAIL_CMD : TAIL_DONE;
            end else begin
                entry_c.tail = TAIL_NONE;
            end
        end
    end

    assign o_push  = adv && (is_start || (is_word && (in_win || page_end)));
    assign o_entry = entry_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page       <= '0;
            r_off        <= '0;
            r_words_left <= '0;
            r_busy       <= 1'b0;
            r_count      <= '0;
        end else if (adv) begin
            if (is_start) begin
                r_page  <= s_base;
                r_off   <= neg_mis;
                r_count <= s_req.count;
                r_busy  <= start_more;
                if (start_more) begin
                    r_words_left <= WL_FULL;
                end
            end else if (is_word) begin
                r_off        <= n_off;
                r_words_left <= r_words_left - WL_W'(1);
                if (page_end) begin
                    r_page <= n_page;
                    r_busy <= word_more;
                    if (word_more) begin
                        r_words_left <= WL_FULL;
                    end
                end
            end
        end
    end

    `CPRS_ASSERT_NOW(a_busy_has_words, i_clk, i_rst_n, r_busy, r_words_left != '0)
    `CPRS_ASSERT_NOW(a_idle_no_words, i_clk, i_rst_n, !r_busy, r_words_left == '0)

endmodule
`default_nettype wire

// ===== hw/rtl/cprs_queue.sv =====
// Short entry queue between the front end and the result stage.
`default_nettype none
`include "cartridge_page_read_sequencer_top_macros.svh"
module cprs_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cprs_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output cprs_pkg::t_entry       o_head,
    output logic                   o_empty,
    output logic                   o_full
);
    import cprs_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);

    `CPRS_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `CPRS_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `CPRS_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `CPRS_ASSERT_NOW(a_ptr_gap, i_clk, i_rst_n, o_empty, r_wr_ptr == r_rd_ptr)

endmodule
`default_nettype wire

// ===== hw/rtl/cprs_back.sv =====
// Result stage: splits queue entries into output beats behind an output register.
`default_nettype none
module cprs_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cprs_pkg::t_entry  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic [151:0]           o_tdata,
    output logic [1:0]             o_tuser,
    output logic                   o_tlast
);
    import cprs_pkg::*;

    logic          load;
    logic          wr_phase;
    logic          r_valid;
    logic          r_half;
    logic          n_half;
    logic [1:0]    n_kind;
    logic [63:0]   n_cmd;
    logic [31:0]   n_ctrl;
    logic [23:0]   n_off;
    logic [31:0]   n_data;
    logic          n_last;
    logic [1:0]    r_kind;
    logic [63:0]   r_cmd;
    logic [31:0]   r_ctrl;
    logic [23:0]   r_off;
    logic [31:0]   r_data;
    logic          r_last;

    assign load     = !r_valid || i_tready;
    // The write beat of an entry goes first; r_half marks it as sent
    assign wr_phase = i_head.wr_en && !r_half;

    always_comb begin
        n_kind = KIND_DONE;
        n_cmd  = '0;
        n_ctrl = '0;
        n_off  = '0;
        n_data = '0;
        n_last = 1'b1;
        n_half = 1'b0;
        o_pop  = 1'b0;
        if (wr_phase) begin
            n_kind = KIND_WRITE;
            n_off  = i_head.offset;
            n_data = i_head.data;
            n_last = i_head.tail == TAIL_NONE;
            n_half = i_head.tail != TAIL_NONE;
            o_pop  = load && !i_empty && (i_head.tail == TAIL_NONE);
        end else begin
            o_pop = load && !i_empty;
            case (i_head.tail)
                TAIL_CMD: begin
                    n_kind = KIND_CMD;
                    n_cmd  = {READ_PAGE_OPCODE, i_head.page, 24'h000000};
                    n_ctrl = i_head.ctrl;
                end
                default: begin
                    n_kind = KIND_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_half <= n_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind <= n_kind;
            r_cmd  <= n_cmd;
            r_ctrl <= n_ctrl;
            r_off  <= n_off;
            r_data <= n_data;
            r_last <= n_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_data, r_off, r_ctrl, r_cmd};
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

endmodule
`default_nettype wire

// ===== hw/rtl/cartridge_page_read_sequencer_top.sv =====
// Cartridge ROM page read sequencer: stream in, command/write/done stream out.
//
// s_axis carries start requests (tuser 0) and card data words (tuser 1).
// m_axis carries results: page read commands, destination writes and done,
// the kind in tuser, tlast on the final result of each input item.
// The control word sent with each command is set through the APB port at
// address 0; write it only while no request is in flight.
// One item is taken per cycle while the queue has a free slot. An item
// passes three stages that split the address into page base and
// misalignment (reciprocal multiply and correction), one stage that updates
// the request state, and a four-entry queue before the output register.
// An item with two results (a write and a command or done) takes two
// output beats, so a long run of such items is held back by the single
// output port.
// A stalled receiver fills the queue; s_axis_tready then drops and the
// front stops, losing nothing.
// Reset leaves the block idle with an empty queue and a zero control word.
`default_nettype none
module cartridge_page_read_sequencer_top #(
    parameter int unsigned PAGE_BYTES = cprs_pkg::PAGE_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] start_address, [55:32] byte_count, [87:56] data_word
    input  wire logic [87:0]   s_axis_tdata,
    // [0] action
    input  wire logic          s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [63:0] command_bytes, [95:64] control_word, [119:96] dest_offset,
    // [151:120] write_data
    output logic [151:0]       m_axis_tdata,
    // [1:0] kind
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cprs_pkg::*;

    logic [31:0] r_page_read_control;
    logic        reg_hit;
    t_req        req;
    t_entry      push_entry, head;
    logic        push, pop, q_empty, q_full;

    // Registers sit on 4-byte boundaries; the low address bits are ignored
    assign reg_hit = paddr[2] == REG_PAGE_READ_CONTROL;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? r_page_read_control : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_read_control <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_page_read_control <= pwdata;
        end
    end

    assign req.action = s_axis_tuser;
    assign req.count  = s_axis_tdata[55:32];
    assign req.data   = s_axis_tdata[87:56];

    cprs_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (req),
        .i_addr  (s_axis_tdata[31:0]),
        .i_ctrl  (r_page_read_control),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    cprs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cprs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
